[rtl/core/gbs_pkg.sv]
// shared types and constants for greedy box suppression
`default_nettype none
package gbs_pkg;

  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);
  localparam int COORD_W   = 12;
  localparam int SCORE_W   = 16;
  localparam int OVL_W     = 17;
  localparam logic [OVL_W-1:0] RESET_OVERLAP = 17'd19661;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [COORD_W-1:0] h;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  typedef struct packed {
    logic load;
    logic scan_issue;
    logic swap;
    logic filt_issue;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic scan_more;
    logic filt_more;
    logic busy;
    logic good_zero;
  } status_t;

endpackage
`default_nettype wire

[rtl/core/gbs_ram.sv]
// generic single write, single read ram with registered read
`default_nettype none
module gbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/gbs_ctrl.sv]
// controller state machine for load, scan, swap, filter, drain and emit
`default_nettype none
module gbs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_tlast,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire gbs_pkg::status_t status,
  output gbs_pkg::cmd_t         cmd
);
  import gbs_pkg::*;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_SWAP  = 6'b000100,
    ST_FILT  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tlast) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status.scan_more) begin
          cmd.scan_issue = 1'b1;
        end else begin
          state_nxt = ST_SWAP;
        end
      end
      ST_SWAP: begin
        cmd.swap  = 1'b1;
        state_nxt = ST_FILT;
      end
      ST_FILT: begin
        if (status.filt_more) begin
          cmd.filt_issue = 1'b1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.emit_done = 1'b1;
          state_nxt     = status.good_zero ? ST_LOAD : ST_SCAN;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/gbs_datapath.sv]
// box store, counters, best search and overlap test pipeline
`default_nettype none
module gbs_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire gbs_pkg::cmd_t             cmd,
  output gbs_pkg::status_t               status,
  input  wire gbs_pkg::box_t             in_box,
  input  wire logic                      in_last,
  input  wire logic                      cfg_wr_en,
  input  wire logic [gbs_pkg::OVL_W-1:0] cfg_wr_data,
  output gbs_pkg::box_t                  win_box,
  output logic                           win_last
);
  import gbs_pkg::*;

  logic [CNT_W-1:0] count_r, base_r, n_r, good_r, idx_r, rd_idx_r;
  logic [OVL_W-1:0] ovl_r;
  logic             sv_r;
  logic [4:0]       fv_r;
  box_t             front_r, best_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [2*COORD_W-1:0] area_a_r;

  logic             we;
  logic [IDX_W-1:0] waddr;
  box_t             wdata, dout;
  logic [BOX_W-1:0] rdata;
  logic [CNT_W-1:0] end_idx, put_idx;

  // overlap pipeline
  logic [COORD_W:0]     ea_x, eb_x, ea_y, eb_y, hi_x, hi_y, lo_x, lo_y, ix, iy;
  logic [COORD_W:0]     ix1_r, iy1_r;
  logic [2*COORD_W-1:0] ab1_r, ab2_r;
  logic [2*COORD_W+1:0] inter2_r, inter3_r, inter4_r, uni3_r, uhi4_r;
  logic [2*COORD_W+17:0] prod4_r;
  logic [2*COORD_W+18:0] lhs, rhs;
  box_t                 b1_r, b2_r, b3_r, b4_r;
  logic                 keep;

  gbs_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign dout    = box_t'(rdata);
  assign end_idx = base_r + n_r;
  assign put_idx = base_r + good_r + CNT_W'(1);

  assign lo_x = {1'b0, (best_r.x > dout.x) ? best_r.x : dout.x};
  assign lo_y = {1'b0, (best_r.y > dout.y) ? best_r.y : dout.y};
  assign ea_x = {1'b0, best_r.x} + {1'b0, best_r.w};
  assign eb_x = {1'b0, dout.x} + {1'b0, dout.w};
  assign ea_y = {1'b0, best_r.y} + {1'b0, best_r.h};
  assign eb_y = {1'b0, dout.y} + {1'b0, dout.h};
  assign hi_x = (ea_x < eb_x) ? ea_x : eb_x;
  assign hi_y = (ea_y < eb_y) ? ea_y : eb_y;
  assign ix   = (hi_x > lo_x) ? hi_x - lo_x : '0;
  assign iy   = (hi_y > lo_y) ? hi_y - lo_y : '0;

  assign lhs  = {1'b0, inter4_r, 16'b0};
  assign rhs  = {1'b0, prod4_r} + {1'b0, uhi4_r, 16'b0};
  assign keep = lhs <= rhs;

  always_comb begin
    we    = 1'b0;
    waddr = count_r[IDX_W-1:0];
    wdata = in_box;
    priority if (cmd.load) begin
      we = count_r < CNT_W'(MAX_BOXES);
    end else if (cmd.swap) begin
      we    = 1'b1;
      waddr = best_idx_r;
      wdata = front_r;
    end else if (fv_r[4] && keep) begin
      we    = 1'b1;
      waddr = put_idx[IDX_W-1:0];
      wdata = b4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      base_r  <= '0;
      n_r     <= '0;
      good_r  <= '0;
      idx_r   <= '0;
      ovl_r   <= RESET_OVERLAP;
      sv_r    <= 1'b0;
      fv_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        ovl_r <= cfg_wr_data;
      end
      sv_r <= cmd.scan_issue;
      fv_r <= {fv_r[3:0], cmd.filt_issue};
      if (cmd.load) begin
        if (in_last) begin
          count_r <= '0;
          n_r     <= (count_r < CNT_W'(MAX_BOXES)) ? count_r + CNT_W'(1) : count_r;
          base_r  <= '0;
          idx_r   <= '0;
        end else if (count_r < CNT_W'(MAX_BOXES)) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (cmd.scan_issue || cmd.filt_issue) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.swap) begin
        idx_r  <= base_r + CNT_W'(1);
        good_r <= '0;
      end
      if (fv_r[4] && keep) begin
        good_r <= good_r + CNT_W'(1);
      end
      if (cmd.emit_done) begin
        base_r <= base_r + CNT_W'(1);
        idx_r  <= base_r + CNT_W'(1);
        n_r    <= good_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r;
    if (sv_r) begin
      if (rd_idx_r == base_r) begin
        front_r    <= dout;
        best_r     <= dout;
        best_idx_r <= rd_idx_r[IDX_W-1:0];
      end else if (dout.score > best_r.score) begin
        best_r     <= dout;
        best_idx_r <= rd_idx_r[IDX_W-1:0];
      end
    end
    if (cmd.swap) begin
      area_a_r <= best_r.w * best_r.h;
    end
    ix1_r    <= ix;
    iy1_r    <= iy;
    ab1_r    <= dout.w * dout.h;
    b1_r     <= dout;
    inter2_r <= ix1_r * iy1_r;
    ab2_r    <= ab1_r;
    b2_r     <= b1_r;
    uni3_r   <= {2'b0, area_a_r} + {2'b0, ab2_r} - inter2_r;
    inter3_r <= inter2_r;
    b3_r     <= b2_r;
    prod4_r  <= ovl_r[15:0] * uni3_r;
    uhi4_r   <= ovl_r[16] ? uni3_r : '0;
    inter4_r <= inter3_r;
    b4_r     <= b3_r;
  end

  assign status.scan_more = idx_r < end_idx;
  assign status.filt_more = idx_r < end_idx;
  assign status.busy      = |fv_r;
  assign status.good_zero = good_r == '0;

  assign win_box  = best_r;
  assign win_last = good_r == '0;

endmodule
`default_nettype wire

[rtl/core/greedy_box_suppression_top.sv]
// top level of greedy box suppression
//
//  channel | dir | handshake            | payload
//  in_     | in  | tvalid/tready        | tdata box, tlast ends set
//  out_    | out | tvalid/tready        | tdata kept box, tlast final kept
//  cfg_    | in  | wr_en                | wr_data overlap limit
//
// loading accepts one item per cycle; the set is held in a 64-entry ram
// each round reads the n remaining boxes once for the best score, writes one swap,
// then streams n-1 boxes through a 5-stage overlap test
// the scan and filter passes share the single ram read port; input is held off until the last kept item
// reset clears counters and control; the box ram needs no clearing
// a stalled output item holds the block until it is taken
`default_nettype none
module greedy_box_suppression_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // box_x, box_y, box_w, box_h, box_score
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [63:0] out_tdata,  // kept_x, kept_y, kept_w, kept_h, kept_score
  output logic             out_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic [16:0] cfg_wr_data
);
  import gbs_pkg::*;

  cmd_t    cmd;
  status_t status;
  box_t    win_box;

  gbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  gbs_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_box      (box_t'(in_tdata)),
    .in_last     (in_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .win_box     (win_box),
    .win_last    (out_tlast)
  );

  assign out_tdata = win_box;

endmodule
`default_nettype wire

[rtl/core/gbs_checker.sv]
// port checker for greedy box suppression, bound to the top level
`default_nettype none
module gbs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output item changed");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while output item pending");

  a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("input not reopened after final kept item");

  a_load_continues: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> in_tready)
    else $error("input closed mid set");

  a_set_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still open after set end");

endmodule

bind greedy_box_suppression_top gbs_checker u_gbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
